@@ src/mbps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Register indexes, field widths and the configuration record.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned RegPatternBytes = 16;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned AddrW           = 64;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CareW           = 16;
  localparam int unsigned LenW            = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow  = 3'd0,
    CfgPatternHigh = 3'd1,
    CfgCareMask    = 3'd2,
    CfgPatternLen  = 3'd3,
    CfgBaseAddr    = 3'd4,
    CfgReportAll   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgDataW-1:0] pattern_low_bytes;
    logic [CfgDataW-1:0] pattern_high_bytes;
    logic [CareW-1:0]    care_mask;
    logic [LenW-1:0]     pattern_length;
    logic [AddrW-1:0]    base_address;
    logic                report_all;
  } cfg_t;

endpackage

@@ src/mbps_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps channel interfaces
// Byte input, result output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface mbps_in_if;
  logic                          valid;
  logic                          ready;
  logic [mbps_pkg::ByteW-1:0]    data_byte;
  logic                          first_byte;
  logic                          last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface mbps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [mbps_pkg::AddrW-1:0]    match_address;
  logic                          range_done;

  modport source (output valid, found, match_address, range_done, input ready);
  modport sink   (input valid, found, match_address, range_done, output ready);
endinterface

interface mbps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mbps_pkg::CfgIdxW-1:0]  index;
  logic [mbps_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/masked_byte_pattern_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: wildcard byte signature scan
// Streams bytes through a sliding window and reports pattern matches.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle while the input is not stalled,
// and gives at most one result per byte. A byte accepted is shifted into the
// window register; the masked compare and the address add read that register
// and land in the result register when that register is free.
// The result register decouples the two
// sides: a new byte is taken while a result waits, and the input only stalls
// when the window stage holds a byte and the result register is full and not
// being drained. Mark the first byte of each range with first_byte and the
// final one with last_byte. In find-first mode (report_all = 0) the first
// match ends the range; in find-all mode every match is reported and the
// range closes on its last byte, which carries range_done (with found = 0
// and a zero address when that byte did not match). Bytes after a closed
// range give nothing until the next first_byte. Write registers only while
// the block is idle; the register channel is always ready.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int unsigned MaxPatternBytes = 16,
  parameter int unsigned OffsetBits      = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbps_cfg_if.sink          cfg_i,
  mbps_in_if.sink           byte_i,
  mbps_out_if.source        result_o
);

  // Register file
  mbps_pkg::cfg_t cfg_q;
  logic           cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_fire) begin
      unique case (mbps_pkg::cfg_reg_e'(cfg_i.index))
        mbps_pkg::CfgPatternLow:  cfg_q.pattern_low_bytes  <= cfg_i.data;
        mbps_pkg::CfgPatternHigh: cfg_q.pattern_high_bytes <= cfg_i.data;
        mbps_pkg::CfgCareMask:    cfg_q.care_mask          <= cfg_i.data[mbps_pkg::CareW-1:0];
        mbps_pkg::CfgPatternLen:  cfg_q.pattern_length     <= cfg_i.data[mbps_pkg::LenW-1:0];
        mbps_pkg::CfgBaseAddr:    cfg_q.base_address       <= cfg_i.data[mbps_pkg::AddrW-1:0];
        mbps_pkg::CfgReportAll:   cfg_q.report_all         <= cfg_i.data[0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Window stage: the window and byte count are both the scan state and the
  // item register for the compare stage.
  logic [MaxPatternBytes-1:0][mbps_pkg::ByteW-1:0] win_q, win_d;
  logic [OffsetBits-1:0]                          cnt_q, cnt_d;
  logic                                           win_vld_q;
  logic                                           first_q;
  logic                                           last_q;
  logic                                           in_fire;
  logic                                           out_free;
  logic                                           take_b;

  logic                                           out_vld_q;
  logic                                           found_q;
  logic [mbps_pkg::AddrW-1:0]                     addr_q;
  logic                                           done_q;

  assign out_free     = !out_vld_q || result_o.ready;
  assign take_b       = win_vld_q && out_free;
  assign byte_i.ready = !win_vld_q || out_free;
  assign in_fire      = byte_i.valid && byte_i.ready;

  // Shift in the new byte; a first byte restarts the window and count.
  always_comb begin
    for (int k = MaxPatternBytes - 1; k > 0; k--) begin
      win_d[k] = byte_i.first_byte ? '0 : win_q[k-1];
    end
    win_d[0] = byte_i.data_byte;
    if (byte_i.first_byte) begin
      cnt_d = OffsetBits'(1);
    end else if (cnt_q == '1) begin
      cnt_d = cnt_q;
    end else begin
      cnt_d = cnt_q + OffsetBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= 1'b0;
      win_q     <= '0;
      cnt_q     <= '0;
      first_q   <= 1'b0;
      last_q    <= 1'b0;
    end else if (in_fire) begin
      win_vld_q <= 1'b1;
      win_q     <= win_d;
      cnt_q     <= cnt_d;
      first_q   <= byte_i.first_byte;
      last_q    <= byte_i.last_byte;
    end else if (take_b) begin
      win_vld_q <= 1'b0;
    end
  end

  // Compare stage
  logic                       hit;
  logic                       finished_q;
  logic                       closed;
  logic                       emit;
  logic                       done_d;
  logic [mbps_pkg::AddrW-1:0] addr_d;

  mbps_match #(
    .MaxPatternBytes (MaxPatternBytes),
    .OffsetBits      (OffsetBits)
  ) u_match (
    .win_i (win_q),
    .cnt_i (cnt_q),
    .cfg_i (cfg_q),
    .hit_o (hit)
  );

  // A first byte reopens a closed range before its own compare.
  assign closed = finished_q && !first_q;
  assign emit   = !closed && (hit || last_q);
  assign done_d = hit ? (last_q || !cfg_q.report_all) : 1'b1;
  assign addr_d = hit ? cfg_q.base_address + mbps_pkg::AddrW'(cnt_q)
                        - mbps_pkg::AddrW'(cfg_q.pattern_length)
                      : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b0;
    end else if (take_b) begin
      finished_q <= closed || (emit && done_d);
    end
  end

  // Result register: hold until taken, reload from the compare stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take_b) begin
      out_vld_q <= emit;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_b && emit) begin
      found_q <= hit;
      addr_q  <= addr_d;
      done_q  <= done_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.found         = found_q;
  assign result_o.match_address = addr_q;
  assign result_o.range_done    = done_q;

`ifndef ASSERT_OFF
  a_miss_closes_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !found_q |-> done_q && (addr_q == '0))
    else $error("not-found result must close the range with a zero address");

  a_done_sets_finished : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_b && emit && done_d |=> finished_q)
    else $error("range not marked finished after its final result");

  a_quiet_after_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_b && finished_q && !first_q |=> !out_vld_q)
    else $error("result produced for a byte of a closed range");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_vld_q |-> cnt_q != '0)
    else $error("byte in window stage with zero byte count");
`endif

endmodule

@@ src/mbps_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match: masked window compare
// Checks whether the pattern starts pattern_length bytes back in the window.
// ----------------------------------------------------------------------------
module mbps_match #(
  parameter int unsigned MaxPatternBytes = 16,
  parameter int unsigned OffsetBits      = 32
) (
  input  logic [MaxPatternBytes-1:0][mbps_pkg::ByteW-1:0] win_i,
  input  logic [OffsetBits-1:0]                          cnt_i,
  input  mbps_pkg::cfg_t                                 cfg_i,
  output logic                                           hit_o
);

  localparam int unsigned NPat = mbps_pkg::RegPatternBytes;

  logic [NPat-1:0][mbps_pkg::ByteW-1:0] view;
  logic [NPat-1:0][mbps_pkg::ByteW-1:0] pat;
  logic [NPat-1:0]                      miss;
  logic [mbps_pkg::LenW-1:0]            len;
  logic                                 len_ok;
  logic                                 seen_ok;

  // Taps beyond the window depth read as zero; they are never selected.
  for (genvar j = 0; j < NPat; j++) begin : g_view
    if (j < MaxPatternBytes) begin : g_tap
      assign view[j] = win_i[j];
    end else begin : g_none
      assign view[j] = '0;
    end
  end

  assign pat     = {cfg_i.pattern_high_bytes, cfg_i.pattern_low_bytes};
  assign len     = cfg_i.pattern_length;
  assign len_ok  = (len != '0) && (32'(len) <= NPat) && (32'(len) <= MaxPatternBytes);
  assign seen_ok = cnt_i >= OffsetBits'(len);

  // Pattern byte i lines up with window tap len-1-i.
  for (genvar i = 0; i < NPat; i++) begin : g_cmp
    logic [mbps_pkg::LenW-1:0] pos;
    assign pos     = len - mbps_pkg::LenW'(1) - mbps_pkg::LenW'(i);
    assign miss[i] = (mbps_pkg::LenW'(i) < len) && cfg_i.care_mask[i] &&
                     (view[pos[3:0]] != pat[i]);
  end

  assign hit_o = len_ok && seen_ok && (miss == '0);

endmodule
